>>> hdl/sqmm_pkg.sv
// Shared definitions for the square matrix multiplier: field widths, defaults
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sqmm_pkg;

  // Width of one element of the product matrix.
  localparam int C_WIDTH = 35;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_SIZE      = 8;
  localparam int DEF_ELEMENT_WIDTH = 16;

  // Size register.
  localparam int SIZE_LOG2_W = 2;
  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_SHOW
  } state_t;

endpackage

`default_nettype wire

>>> hdl/sqmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/square_matrix_multiplier_unit.sv
// Top level of the square matrix multiplier: loads A and B pairwise, then
// forms C = A * B with one shared multiply-accumulate. Uses sqmm_pkg and sqmm_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Contents
// pair      in         pair_valid/pair_stall   a_value, b_value (row-major)
// result    out        result_valid/result_stall  c_value, last (row-major)
// cfg       in         cfg_valid/cfg_ready     size_log2
//
// Pairs are taken one per cycle until the whole matrix of d*d pairs is loaded
// (d = 1 << size_log2, capped at MAX_SIZE). Each element of C is then formed
// from d reads of the two element memories through the single multiplier,
// passing the memory read register, the product register and the output register.
// Reset is synchronous and returns the size to 8 and the load count to zero.
// While the result channel is stalled the sequencer waits in place; no pairs
// and no configuration requests are taken until the final element has gone.

module square_matrix_multiplier_unit #(
  parameter int MAX_SIZE      = sqmm_pkg::DEF_MAX_SIZE,
  parameter int ELEMENT_WIDTH = sqmm_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // pair channel
  input  wire logic                                   pair_valid,
  output logic                                        pair_stall,
  input  wire logic signed [ELEMENT_WIDTH-1:0]        a_value,
  input  wire logic signed [ELEMENT_WIDTH-1:0]        b_value,
  // result channel
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic signed [sqmm_pkg::C_WIDTH-1:0]         c_value,
  output logic                                        last,
  // configuration channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [sqmm_pkg::SIZE_LOG2_W-1:0]       size_log2
);

  import sqmm_pkg::*;

  localparam int MAX_LOG2 = $clog2(MAX_SIZE);
  localparam int IDX_W    = MAX_LOG2;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PROD_W   = 2 * ELEMENT_WIDTH;
  localparam int ACC_W    = (PROD_W > C_WIDTH) ? PROD_W : C_WIDTH;

  state_t state, state_next;

  logic [SIZE_LOG2_W-1:0] size_q;
  logic [SIZE_LOG2_W-1:0] lg_eff;
  logic [IDX_W-1:0]       dim_m1;
  logic [ADDR_W-1:0]      tot_m1;

  logic [ADDR_W-1:0] load_count;
  logic [IDX_W-1:0]  row, col, kk;
  logic              issuing;
  logic              rd_vld, rd_lst, mul_vld, mul_lst;

  logic [ADDR_W-1:0]        a_rd_addr, b_rd_addr;
  logic [ELEMENT_WIDTH-1:0] a_rd, b_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_sum;
  logic signed [C_WIDTH-1:0] c_q;
  logic                      last_q;

  logic pair_acc, cfg_wr, res_take, load_done, fin, elem_last;

  // The dimension in use saturates at MAX_SIZE, so the shift is clipped too.
  assign lg_eff = (size_q > SIZE_LOG2_W'(MAX_LOG2)) ? SIZE_LOG2_W'(MAX_LOG2) : size_q;
  assign dim_m1 = ~({IDX_W{1'b1}} << lg_eff);
  assign tot_m1 = ~({ADDR_W{1'b1}} << {lg_eff, 1'b0});

  assign pair_acc  = pair_valid && !pair_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign res_take  = result_valid && !result_stall;
  assign load_done = pair_acc && (load_count == tot_m1);
  assign fin       = mul_vld && mul_lst;
  assign elem_last = (row == dim_m1) && (col == dim_m1);

  // Row-major addresses: A[row][k] and B[k][col].
  assign a_rd_addr = (ADDR_W'(row) << lg_eff) | ADDR_W'(kk);
  assign b_rd_addr = (ADDR_W'(kk) << lg_eff) | ADDR_W'(col);

  sqmm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_a_ram (
    .clk     (clk),
    .wr_en   (pair_acc),
    .wr_addr (load_count),
    .wr_data (a_value),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd)
  );

  sqmm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk     (clk),
    .wr_en   (pair_acc),
    .wr_addr (load_count),
    .wr_data (b_value),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (load_done) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (fin) state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (res_take) state_next = last_q ? ST_LOAD : ST_CALC;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Handshake outputs follow the state alone.
  always_comb begin
    pair_stall   = 1'b1;
    cfg_ready    = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        pair_stall = 1'b0;
        cfg_ready  = 1'b1;
      end
      ST_CALC: begin
        pair_stall = 1'b1;
      end
      ST_SHOW: begin
        result_valid = 1'b1;
      end
      default: begin
        pair_stall = 1'b1;
      end
    endcase
  end

  // Control registers: state, size, load position and the index counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      size_q     <= SIZE_LOG2_RESET;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      kk         <= '0;
      issuing    <= 1'b0;
      rd_vld     <= 1'b0;
      rd_lst     <= 1'b0;
      mul_vld    <= 1'b0;
      mul_lst    <= 1'b0;
    end else begin
      state <= state_next;

      // A size write restarts the load.
      if (cfg_wr) begin
        size_q     <= size_log2;
        load_count <= '0;
      end else if (pair_acc) begin
        load_count <= load_done ? '0 : load_count + 1'b1;
      end

      if (load_done) begin
        row     <= '0;
        col     <= '0;
        kk      <= '0;
        issuing <= 1'b1;
      end else if (issuing) begin
        kk <= kk + 1'b1;
        if (kk == dim_m1) issuing <= 1'b0;
      end else if (res_take && !last_q) begin
        // Step to the next element of C in row-major order.
        kk      <= '0;
        issuing <= 1'b1;
        if (col == dim_m1) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end

      rd_vld  <= issuing;
      rd_lst  <= issuing && (kk == dim_m1);
      mul_vld <= rd_vld;
      mul_lst <= rd_lst;
    end
  end

  assign acc_sum = acc + ACC_W'(prod);

  // Datapath: one multiplier, one accumulator, one output register.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= $signed(a_rd) * $signed(b_rd);
    end
    if (load_done || fin) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc_sum;
    end
    if (fin) begin
      c_q    <= acc_sum[C_WIDTH-1:0];
      last_q <= elem_last;
    end
  end

  assign c_value = c_q;
  assign last    = last_q;

endmodule

`default_nettype wire

>>> verif/tb_square_matrix_multiplier_unit.sv
// Self-checking testbench for square_matrix_multiplier_unit: streams A/B element pairs,
// predicts every element of C = A * B and checks each result request in order.
// Depends on sqmm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_square_matrix_multiplier_unit;
  import sqmm_pkg::*;

  localparam int MAX_SIZE    = DEF_MAX_SIZE;
  localparam int EW          = DEF_ELEMENT_WIDTH;
  localparam int CW          = C_WIDTH;
  localparam int SW          = SIZE_LOG2_W;
  localparam int MAX_CELLS   = MAX_SIZE * MAX_SIZE;
  localparam int SETTLE      = 40;     // longer than one element of C takes to form
  localparam int HOLD_CYCLES = 1600;   // longer than a whole 8 x 8 load and calculation
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 72;

  localparam logic signed [EW-1:0] EL_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] EL_MAX = {1'b0, {(EW-1){1'b1}}};

  typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_e;
  typedef enum int {FILL_UNIFORM, FILL_CORNER, FILL_SMALL, FILL_FLOOR, FILL_OPPOSE} fill_e;

  typedef struct {
    row_kind_e               kind;
    logic [SW-1:0]           size;
    logic signed [EW-1:0]    a;
    logic signed [EW-1:0]    b;
    bit                      typed;
    logic signed [CW-1:0]    c;
  } stim_row_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic                 last;
  } c_elem_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pair_valid = 1'b0;
  logic                 pair_stall;
  logic signed [EW-1:0] a_value = '0;
  logic signed [EW-1:0] b_value = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic signed [CW-1:0] c_value;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SW-1:0]        size_log2 = SIZE_LOG2_RESET;

  square_matrix_multiplier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .a_value      (a_value),
    .b_value      (b_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .c_value      (c_value),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .size_log2    (size_log2)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Own copy of the block's state: the size in use, the pairs held so far and
  // the product elements still owed on the result channel, oldest first.
  logic [SW-1:0]        size_now;
  logic signed [EW-1:0] a_mat [MAX_CELLS];
  logic signed [EW-1:0] b_mat [MAX_CELLS];
  int                   pairs_held;
  c_elem_t              pending_products [$];

  stim_row_t stim_rows [$];
  int        err_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        phase_items;
  bit        hold_off = 1'b0;
  bit        pressure_go = 1'b0;
  int        quiet_cycles = 0;

  // Stores one accepted pair; on the last pair of the matrix it forms every
  // element of C in row-major order. A typed value, used only for 1 x 1
  // matrices, stands in for the computed element.
  task automatic accumulate_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                                 input bit typed, input logic signed [CW-1:0] typed_c);
    int dim, total, i, j, k;
    longint acc;
    c_elem_t elem;
    dim = 1 << size_now;
    if (dim > MAX_SIZE) dim = MAX_SIZE;
    total = dim * dim;
    if (pairs_held >= total) pairs_held = 0;
    a_mat[pairs_held] = a;
    b_mat[pairs_held] = b;
    pairs_held++;
    if (pairs_held < total) return;
    pairs_held = 0;
    for (i = 0; i < dim; i++) begin
      for (j = 0; j < dim; j++) begin
        acc = 0;
        for (k = 0; k < dim; k++) begin
          acc += longint'(a_mat[i*dim + k]) * longint'(b_mat[k*dim + j]);
        end
        elem.c    = typed ? typed_c : acc[CW-1:0];
        elem.last = (i*dim + j == total - 1);
        pending_products.push_back(elem);
      end
    end
  endtask

  // Driver tasks are entered just after a falling edge and leave just after one.
  task automatic send_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                           input bit typed, input logic signed [CW-1:0] typed_c);
    while ($urandom_range(99) < idle_pct) begin
      pair_valid <= 1'b0;
      @(negedge clk);
    end
    pair_valid <= 1'b1;
    a_value    <= a;
    b_value    <= b;
    do @(posedge clk); while (pair_stall);
    accumulate_pair(a, b, typed, typed_c);
    @(negedge clk);
  endtask

  // The size is only changed once every owed element has been taken and the
  // block has had time to finish any calculation in flight.
  task automatic write_size(input logic [SW-1:0] v);
    pair_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    size_log2 <= v;
    do @(posedge clk); while (!cfg_ready);
    size_now   = v;
    pairs_held = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [EW-1:0] pick_element(input fill_e fill, input bit is_b);
    logic signed [EW-1:0] corners [4];
    corners = '{EL_MIN, EL_MAX, '0, '1};
    case (fill)
      FILL_CORNER: return corners[$urandom_range(3)];
      FILL_SMALL:  return EW'($signed($urandom_range(15)) - 8);
      FILL_FLOOR:  return EL_MIN;
      FILL_OPPOSE: return is_b ? EL_MAX : EL_MIN;
      default:     return EW'($urandom);
    endcase
  endfunction

  task automatic send_matrix(input int n, input fill_e fill);
    int i;
    for (i = 0; i < n; i++) begin
      send_pair(pick_element(fill, 1'b0), pick_element(fill, 1'b1), 1'b0, '0);
      phase_items++;
    end
  endtask

  // Mostly whole matrices at small sizes; now and then an 8 x 8, and now and
  // then a load cut short by a size write, which restarts it.
  task automatic run_matrix_job();
    int pick, total, n;
    logic [SW-1:0] sz;
    pick = $urandom_range(9);
    sz = (pick == 0) ? SW'(3) : (pick < 4) ? SW'(2) : (pick < 7) ? SW'(1) : SW'(0);
    if (sz != size_now || $urandom_range(3) == 0) write_size(sz);
    total = 1 << (2 * sz);
    n = total;
    if (total > 1 && $urandom_range(7) == 0) n = $urandom_range(total - 1, 1);
    send_matrix(n, fill_e'($urandom_range(9) == 0 ? FILL_FLOOR : $urandom_range(2)));
    if (n < total) write_size(size_now);
  endtask

  function automatic void add_cfg(input logic [SW-1:0] v);
    stim_rows.push_back('{ROW_CFG, v, '0, '0, 1'b0, '0});
  endfunction

  function automatic void add_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                                   input bit typed, input logic signed [CW-1:0] c);
    stim_rows.push_back('{ROW_PAIR, '0, a, b, typed, c});
  endfunction

  // Receiver: random stalls, or a solid hold-off while pressure is applied.
  always @(negedge clk) begin
    result_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Each result request is checked against the oldest owed element.
  always @(posedge clk) begin
    c_elem_t exp_elem;
    if (!rst && result_valid && !result_stall) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result, expected none, got c_value %0d last %0b",
                 $time, c_value, last);
        err_count++;
      end else begin
        exp_elem = pending_products.pop_front();
        if (c_value !== exp_elem.c) begin
          $display("%0t: c_value mismatch, expected %0d, got %0d",
                   $time, exp_elem.c, c_value);
          err_count++;
        end
        if (last !== exp_elem.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, exp_elem.last, last);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request accepted on any channel.
  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d elements owed", $time, pending_products.size());
      $display("tb_square_matrix_multiplier_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph, r;

    // 1 x 1 products can be read straight off the operands.
    add_cfg(0);
    add_pair(EL_MIN, EL_MIN, 1'b1, 35'sd1073741824);
    add_pair(EL_MAX, EL_MIN, 1'b1, -35'sd1073709056);
    add_pair(EL_MAX, EL_MAX, 1'b1, 35'sd1073676289);
    add_pair('1, '1, 1'b1, 35'sd1);
    add_pair('0, EL_MIN, 1'b1, 35'sd0);
    // A 2 x 2 load cut short by a size write, then a whole one.
    add_cfg(1);
    add_pair(16'sd5, -16'sd7, 1'b0, '0);
    add_cfg(1);
    add_pair(16'sd1, 16'sd2, 1'b0, '0);
    add_pair(16'sd3, -16'sd4, 1'b0, '0);
    add_pair(EL_MIN, EL_MAX, 1'b0, '0);
    add_pair(EL_MAX, EL_MIN, 1'b0, '0);
    // A 4 x 4 of the most negative element.
    add_cfg(2);
    for (r = 0; r < 16; r++) add_pair(EL_MIN, EL_MIN, 1'b0, '0);

    size_now   = SIZE_LOG2_RESET;
    pairs_held = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        write_size(stim_rows[r].size);
      end else begin
        send_pair(stim_rows[r].a, stim_rows[r].b, stim_rows[r].typed, stim_rows[r].c);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      @(negedge clk);
      phase_items = 0;
      if (ph == 0) begin
        // The receiver holds off while two 8 x 8 matrices are offered without
        // a gap, so the block fills and must stall the pair channel.
        write_size(3);
        pressure_go = 1'b1;
        send_matrix(MAX_CELLS, FILL_FLOOR);
        send_matrix(MAX_CELLS, FILL_OPPOSE);
      end
      while (phase_items < PHASE_ITEMS) run_matrix_job();
    end
    pair_valid <= 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_square_matrix_multiplier_unit: clean");
    end else begin
      $display("tb_square_matrix_multiplier_unit: errors");
    end
    $finish;
  end

endmodule
